/* sv/kadq_pkg.sv */
`default_nettype none
package kadq_pkg;

	localparam int MODE_W      = 2;
	localparam int EXT_TAG_W   = 32;
	localparam int LIMIT_W     = 6;
	localparam int CNT_OUT_W   = 7;
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;

	localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

	// Word index of each configuration register (byte address / 4).
	localparam logic REG_QUEUE_LIMIT = 1'b0;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

	typedef struct packed {
		logic [MODE_W-1:0]    mode;
		logic [EXT_TAG_W-1:0] packet_tag;
		logic                 key_flag;
	} kadq_cmd_t;

	typedef struct packed {
		logic [EXT_TAG_W-1:0] out_tag;
		logic                 out_valid;
		logic [CNT_OUT_W-1:0] occupancy;
		logic [CNT_OUT_W-1:0] dropped_count;
	} kadq_rsp_t;

	typedef struct packed {
		logic shift;
		logic load;
	} kadq_cell_ctl_t;

endpackage
`default_nettype wire

/* sv/kadq_cell.sv */
`default_nettype none
module kadq_cell #(
	parameter int TAG_WIDTH = 32
) (
	input  wire                       clk,
	input  kadq_pkg::kadq_cell_ctl_t  ctl,
	input  wire [TAG_WIDTH-1:0]       load_tag,
	input  wire                       load_key,
	input  wire [TAG_WIDTH-1:0]       next_tag,
	input  wire                       next_key,
	output logic [TAG_WIDTH-1:0]      tag_q,
	output logic                      key_q
);
	import kadq_pkg::*;

	// A new entry has priority over the value moving in from the neighbor.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			tag_q <= load_tag;
			key_q <= load_key;
		end else if (ctl.shift) begin
			tag_q <= next_tag;
			key_q <= next_key;
		end
	end

endmodule
`default_nettype wire

/* sv/kadq_cfg.sv */
`default_nettype none
module kadq_cfg (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                psel,
	input  wire                                penable,
	input  wire                                pwrite,
	input  wire [kadq_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire [kadq_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [kadq_pkg::APB_DATA_W-1:0]    prdata,
	output logic                               pready,
	output logic [kadq_pkg::LIMIT_W-1:0]       queue_limit
);
	import kadq_pkg::*;

	logic [LIMIT_W-1:0] limit_q;
	logic               sel_limit;

	assign pready      = 1'b1;
	assign sel_limit   = (paddr[APB_ADDR_W-1] == REG_QUEUE_LIMIT);
	assign queue_limit = limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && sel_limit) begin
			limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_limit) begin
			prdata = APB_DATA_W'(limit_q);
		end
	end

endmodule
`default_nettype wire

/* sv/keyframe_aware_drop_queue.sv */
// Channel  | Signals                    | Transfer
// ---------+----------------------------+----------------------------------
// command  | start, busy, cmd           | edge with start high, busy low
// result   | done, rsp                  | one cycle, done high, no stall
// config   | psel penable pwrite paddr  | access edge, pready always high
//          | pwdata prdata pready       |
// Pop, clear and idle modes do not set busy; their result shows the cycle after the command.
// A push passes through the check state, and through the drop walk when the queue is over its
// limit: the check drops a key head, then the walk drops the non-key entries behind it up to
// the next key or an empty queue, moving the whole cell chain one place per cycle toward the head.
// After reset the queue is empty and the limit is 32; busy is low.
// busy stays high for the whole push; a new command may enter while a result shows.
`default_nettype none
module keyframe_aware_drop_queue #(
	parameter int DEPTH     = 64,
	parameter int TAG_WIDTH = 32
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               start,
	output logic                              busy,
	input  kadq_pkg::kadq_cmd_t               cmd,
	output logic                              done,
	output kadq_pkg::kadq_rsp_t               rsp,
	input  wire                               psel,
	input  wire                               penable,
	input  wire                               pwrite,
	input  wire [kadq_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire [kadq_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [kadq_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);
	import kadq_pkg::*;

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;
	localparam logic [CW-1:0]   FULL_CNT = CW'(DEPTH);
	localparam logic [CMPW-1:0] TOP_LIM  = CMPW'(DEPTH - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_WALK
	} state_t;

	state_t               state_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        dropped_q;
	logic                 done_q;
	kadq_rsp_t            rsp_q;
	logic [LIMIT_W-1:0]   queue_limit;

	logic [TAG_WIDTH-1:0] tag_cells [DEPTH];
	logic                 key_cells [DEPTH];
	kadq_cell_ctl_t       cell_ctl  [DEPTH];

	logic                 accept;
	logic                 full;
	logic                 over;
	logic                 head_key;
	logic                 shift;
	logic [CMPW-1:0]      lim_ext;
	logic [CMPW-1:0]      lim_eff;
	logic [TAG_WIDTH-1:0] in_tag;

	kadq_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.queue_limit (queue_limit)
	);

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign full     = (count_q == FULL_CNT);
	assign head_key = key_cells[0];
	assign in_tag   = TAG_WIDTH'(cmd.packet_tag);
	assign lim_ext  = CMPW'(queue_limit);
	assign lim_eff  = (lim_ext > TOP_LIM) ? TOP_LIM : lim_ext;
	assign over     = (CMPW'(count_q) > lim_eff);
	assign done     = done_q;
	assign rsp      = rsp_q;

	always_comb begin
		shift = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					shift = ((cmd.mode == MODE_PUSH) && full) ||
					        ((cmd.mode == MODE_POP) && (count_q != '0));
				end
			end
			ST_CHECK: shift = over && head_key;
			ST_WALK:  shift = (count_q != '0) && !head_key;
			default:  shift = 1'b0;
		endcase
	end

	// Cell 0 is the head; each cell takes its upper neighbor's entry on a shift.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CW-1:0] IDX = CW'(i);
		logic load;
		logic [TAG_WIDTH-1:0] nb_tag;
		logic nb_key;

		if (i == DEPTH - 1) begin : g_last
			assign load   = accept && (cmd.mode == MODE_PUSH) && (full || (count_q == IDX));
			assign nb_tag = '0;
			assign nb_key = 1'b0;
		end else begin : g_mid
			assign load   = accept && (cmd.mode == MODE_PUSH) && !full && (count_q == IDX);
			assign nb_tag = tag_cells[i+1];
			assign nb_key = key_cells[i+1];
		end

		assign cell_ctl[i] = '{shift: shift, load: load};

		kadq_cell #(
			.TAG_WIDTH (TAG_WIDTH)
		) u_cell (
			.clk      (clk),
			.ctl      (cell_ctl[i]),
			.load_tag (in_tag),
			.load_key (cmd.key_flag),
			.next_tag (nb_tag),
			.next_key (nb_key),
			.tag_q    (tag_cells[i]),
			.key_q    (key_cells[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			dropped_q <= '0;
			done_q    <= 1'b0;
			rsp_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rsp_q <= '0;
						unique case (cmd.mode)
							MODE_PUSH: begin
								// A push into a full chain drops the head to make room.
								if (full) begin
									dropped_q <= CW'(1);
								end else begin
									count_q   <= count_q + CW'(1);
									dropped_q <= '0;
								end
								state_q <= ST_CHECK;
							end
							MODE_POP: begin
								done_q <= 1'b1;
								if (count_q != '0) begin
									count_q             <= count_q - CW'(1);
									rsp_q.out_tag       <= EXT_TAG_W'(tag_cells[0]);
									rsp_q.out_valid     <= 1'b1;
									rsp_q.occupancy     <= CNT_OUT_W'(count_q - CW'(1));
								end else begin
									rsp_q.occupancy     <= CNT_OUT_W'(count_q);
								end
							end
							MODE_CLEAR: begin
								done_q  <= 1'b1;
								count_q <= '0;
							end
							default: begin
								done_q          <= 1'b1;
								rsp_q.occupancy <= CNT_OUT_W'(count_q);
							end
						endcase
					end
				end
				ST_CHECK: begin
					if (over) begin
						if (head_key) begin
							count_q   <= count_q - CW'(1);
							dropped_q <= dropped_q + CW'(1);
						end
						state_q <= ST_WALK;
					end else begin
						done_q              <= 1'b1;
						rsp_q.occupancy     <= CNT_OUT_W'(count_q);
						rsp_q.dropped_count <= CNT_OUT_W'(dropped_q);
						state_q             <= ST_IDLE;
					end
				end
				ST_WALK: begin
					if ((count_q != '0) && !head_key) begin
						count_q   <= count_q - CW'(1);
						dropped_q <= dropped_q + CW'(1);
					end else begin
						done_q              <= 1'b1;
						rsp_q.occupancy     <= CNT_OUT_W'(count_q);
						rsp_q.dropped_count <= CNT_OUT_W'(dropped_q);
						state_q             <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

/* dv/kadq_checker.sv */
module kadq_checker (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	input  wire                              busy,
	input  kadq_pkg::kadq_cmd_t              cmd,
	input  wire                              done,
	input  kadq_pkg::kadq_rsp_t              rsp,
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire [kadq_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire [kadq_pkg::APB_DATA_W-1:0]   pwdata,
	input  wire [kadq_pkg::APB_DATA_W-1:0]   prdata,
	input  wire                              pready,
	output int                               failures,
	output int                               pending
);
	import kadq_pkg::*;

	localparam int DEPTH = 64;
	localparam logic [APB_ADDR_W-1:0] LIMIT_ADDR = APB_ADDR_W'(REG_QUEUE_LIMIT) << 2;

	logic [EXT_TAG_W-1:0] held_tags [DEPTH];
	logic                 held_keys [DEPTH];
	int                   head_ptr;
	int                   tail_ptr;
	int                   held_count;
	logic [LIMIT_W-1:0]   drop_limit;
	kadq_rsp_t            queued_results [$];

	function automatic void retire_head();
		head_ptr   = (head_ptr + 1) % DEPTH;
		held_count = held_count - 1;
	endfunction

	// Applies one command to the local copy of the queue and returns its result.
	function automatic kadq_rsp_t apply_queue_op(kadq_cmd_t c);
		kadq_rsp_t r;
		int        eff_limit;
		int        drops;
		r = '0;
		drops = 0;
		case (c.mode)
		MODE_PUSH: begin
			eff_limit = (int'(drop_limit) > DEPTH - 1) ? DEPTH - 1 : int'(drop_limit);
			if (held_count >= DEPTH) begin
				retire_head();
				drops++;
			end
			held_tags[tail_ptr] = c.packet_tag;
			held_keys[tail_ptr] = c.key_flag;
			tail_ptr   = (tail_ptr + 1) % DEPTH;
			held_count = held_count + 1;
			if (held_count > eff_limit) begin
				// Drop the oldest group of pictures: its key head, then its non-key tail.
				if (held_keys[head_ptr]) begin
					retire_head();
					drops++;
				end
				while (held_count > 0 && !held_keys[head_ptr]) begin
					retire_head();
					drops++;
				end
			end
		end
		MODE_POP: begin
			if (held_count > 0) begin
				r.out_tag   = held_tags[head_ptr];
				r.out_valid = 1'b1;
				retire_head();
			end
		end
		MODE_CLEAR: begin
			head_ptr   = 0;
			tail_ptr   = 0;
			held_count = 0;
		end
		default: begin
		end
		endcase
		r.occupancy     = CNT_OUT_W'(held_count);
		r.dropped_count = CNT_OUT_W'(drops);
		return r;
	endfunction

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		kadq_rsp_t want;
		if (!arst_n) begin
			head_ptr   = 0;
			tail_ptr   = 0;
			held_count = 0;
			drop_limit = LIMIT_RESET;
			queued_results.delete();
		end else begin
			if (psel && penable && pready && paddr == LIMIT_ADDR) begin
				if (pwrite) begin
					drop_limit = pwdata[LIMIT_W-1:0];
				end else begin
					check_field("prdata", APB_DATA_W'(drop_limit), prdata);
				end
			end
			if (start && !busy) begin
				queued_results.insert(queued_results.size(), apply_queue_op(cmd));
			end
			if (done) begin
				if (queued_results.size() == 0) begin
					$error("result transfer with no command outstanding");
					failures++;
				end else begin
					want = queued_results[0];
					queued_results.delete(0);
					check_field("out_tag", want.out_tag, rsp.out_tag);
					check_field("out_valid", 32'(want.out_valid), 32'(rsp.out_valid));
					check_field("occupancy", 32'(want.occupancy), 32'(rsp.occupancy));
					check_field("dropped_count", 32'(want.dropped_count),
						32'(rsp.dropped_count));
				end
			end
		end
		pending = queued_results.size();
	end

endmodule

/* dv/tb_keyframe_aware_drop_queue.sv */
module tb_keyframe_aware_drop_queue;
	import kadq_pkg::*;

	localparam int DEPTH = 64;
	localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;
	localparam logic [APB_ADDR_W-1:0] LIMIT_ADDR = APB_ADDR_W'(REG_QUEUE_LIMIT) << 2;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 265;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	kadq_cmd_t             cmd;
	logic                  done;
	kadq_rsp_t             rsp;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	int                    failures;
	int                    pending;

	int burst_left;
	int gop_pos;
	int gop_len;

	keyframe_aware_drop_queue uut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .cmd(cmd),
		.done(done), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	kadq_checker queue_checker (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .cmd(cmd),
		.done(done), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.failures(failures), .pending(pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#20000000;
		$display("** keyframe_aware_drop_queue: FAILED **");
		$finish;
	end

	// Holds start high until the command transfer; the next call replaces or drops it.
	task automatic send_cmd(input logic [MODE_W-1:0] m, input logic [EXT_TAG_W-1:0] tag,
			input logic key);
		kadq_cmd_t c;
		int        gap;
		c.mode       = m;
		c.packet_tag = tag;
		c.key_flag   = key;
		if (burst_left > 0) begin
			gap = 0;
			burst_left--;
		end else begin
			gap = $urandom_range(0, 7);
			if ($urandom_range(0, 99) < 3) begin
				burst_left = $urandom_range(10, 40);
			end
		end
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0 || busy) @(negedge clk);
	endtask

	task automatic apb_access(input logic write, input logic [LIMIT_W-1:0] value);
		logic [APB_DATA_W-1:0] word;
		word = $urandom;
		word[LIMIT_W-1:0] = value;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= LIMIT_ADDR;
		pwdata  <= word;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_limit(input logic [LIMIT_W-1:0] value);
		wait_idle();
		apb_access(1'b1, value);
		apb_access(1'b0, '0);
	endtask

	// Keys mostly follow group-of-pictures structure; a tenth are random noise.
	function automatic logic next_key();
		logic k;
		if ($urandom_range(0, 9) == 0) begin
			k = 1'($urandom_range(0, 1));
		end else begin
			k = (gop_pos == 0);
			gop_pos++;
			if (gop_pos >= gop_len) begin
				gop_pos = 0;
				gop_len = $urandom_range(1, 12);
			end
		end
		return k;
	endfunction

	task automatic run_random(input int count, input int clear_per_mille);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 999);
			if (r < 700) begin
				send_cmd(MODE_PUSH, $urandom, next_key());
			end else if (r < 930) begin
				send_cmd(MODE_POP, $urandom, 1'($urandom_range(0, 1)));
			end else if (r < 930 + clear_per_mille) begin
				send_cmd(MODE_CLEAR, $urandom, 1'($urandom_range(0, 1)));
			end else begin
				send_cmd(MODE_NOP, $urandom, 1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin
		logic [LIMIT_W-1:0] limit_plan [PHASES];
		int                 drain;
		int                 total_fail;
		arst_n     = 1'b0;
		start      = 1'b0;
		cmd        = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		burst_left = 0;
		gop_pos    = 0;
		gop_len    = 4;
		limit_plan = '{6'd63, 6'($urandom), 6'd0, 6'($urandom), 6'd63, 6'd1,
			6'($urandom), 6'd32};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset limit of 32: empty-queue cases, tag extremes and clear.
		send_cmd(MODE_POP, 32'h0, 1'b0);
		send_cmd(MODE_NOP, 32'hFFFF_FFFF, 1'b1);
		send_cmd(MODE_PUSH, 32'h0000_0000, 1'b0);
		send_cmd(MODE_PUSH, 32'hFFFF_FFFF, 1'b1);
		send_cmd(MODE_PUSH, 32'hA5A5_A5A5, 1'b0);
		send_cmd(MODE_NOP, 32'h0, 1'b0);
		repeat (4) send_cmd(MODE_POP, 32'h0, 1'b0);
		send_cmd(MODE_PUSH, 32'h5A5A_5A5A, 1'b1);
		send_cmd(MODE_PUSH, 32'h1234_5678, 1'b0);
		send_cmd(MODE_CLEAR, 32'hFFFF_FFFF, 1'b1);
		send_cmd(MODE_POP, 32'h0, 1'b0);

		// A zero limit drops every pushed entry, key or not.
		set_limit(6'd0);
		send_cmd(MODE_PUSH, 32'hDEAD_BEEF, 1'b1);
		send_cmd(MODE_PUSH, 32'hCAFE_F00D, 1'b0);

		// Small limit: whole group dropped, then a drop that stops at the next key.
		set_limit(6'd2);
		send_cmd(MODE_PUSH, 32'h0000_0011, 1'b1);
		send_cmd(MODE_PUSH, 32'h0000_0012, 1'b0);
		send_cmd(MODE_PUSH, 32'h0000_0013, 1'b0);
		send_cmd(MODE_PUSH, 32'h0000_0021, 1'b1);
		send_cmd(MODE_PUSH, 32'h0000_0022, 1'b0);
		send_cmd(MODE_PUSH, 32'h0000_0031, 1'b1);
		send_cmd(MODE_POP, 32'h0, 1'b0);
		send_cmd(MODE_POP, 32'h0, 1'b0);

		for (int p = 0; p < PHASES; p++) begin
			set_limit(limit_plan[p]);
			run_random(PHASE_ITEMS, (limit_plan[p] >= 6'd32) ? 2 : 20);
		end

		@(negedge clk);
		start <= 1'b0;
		drain = 0;
		while (pending != 0 && drain < 5000) begin
			@(negedge clk);
			drain++;
		end
		repeat (DEPTH + 8) @(negedge clk);
		total_fail = failures + pending;
		if (total_fail == 0) begin
			$display("** keyframe_aware_drop_queue: PASSED **");
		end else begin
			$display("** keyframe_aware_drop_queue: FAILED **");
		end
		$finish;
	end

endmodule
